@@ sv/kpb_pkg.sv @@
package kpb_pkg;

   localparam int MAX_BONES = 16;
   localparam int MAX_KEYS  = 8;
   localparam int MAX_CLIPS = 4;

   localparam int BONE_W = 4;
   localparam int KEY_W  = 3;
   localparam int CLIP_W = 2;
   localparam int ELEM_W = 4;
   localparam int KCNT_W = 4;
   localparam int NB_W   = 5;
   localparam int MAT_AW = CLIP_W + KEY_W + BONE_W + ELEM_W;
   localparam int KT_AW  = CLIP_W + KEY_W;

   localparam int DIV_W     = 48;
   localparam int DIV_CNT_W = 6;

   localparam logic [16:0] P_ONE = 17'd65536;

   // request kinds
   localparam logic [2:0] K_TICK     = 3'd0;
   localparam logic [2:0] K_LOAD_MAT = 3'd1;
   localparam logic [2:0] K_LOAD_KEY = 3'd2;
   localparam logic [2:0] K_PLAY     = 3'd3;
   localparam logic [2:0] K_TRANS    = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_BONE_COUNT = 3'd0;
   localparam logic [2:0] CSR_LEN0       = 3'd1;
   localparam logic [2:0] CSR_LEN1       = 3'd2;
   localparam logic [2:0] CSR_LEN2       = 3'd3;
   localparam logic [2:0] CSR_LEN3       = 3'd4;

   typedef enum logic [4:0] {
      ST_IDLE, ST_WRAP, ST_WRAP_W, ST_SRCH, ST_KT0, ST_KT1, ST_FRAC, ST_FRAC_W,
      ST_TR_ADD, ST_TR_CHK, ST_WRAPB, ST_E_INIT, ST_E_RD, ST_E_LD, ST_E_MA,
      ST_E_MB, ST_E_AB, ST_E_MX, ST_E_AF
   } state_type;

   typedef enum logic [1:0] {PH_A, PH_TP, PH_B} phase_type;
   typedef enum logic [1:0] {DV_WRAP_A, DV_WRAP_B, DV_FRAC} div_sel_type;
   typedef enum logic [1:0] {OP_NONE, OP_MEM_A, OP_MEM_B, OP_MIX} op_ld_type;
   typedef enum logic [1:0] {RD_NONE, RD_BASE, RD_COL} res_dst_type;

   typedef struct packed {
      logic        accept;
      logic        div_go;
      div_sel_type div_sel;
      logic        wrap_ld;
      logic        srch_step;
      logic        kt0;
      logic        kt1;
      logic        p_ld;
      logic        tr_add;
      logic        tr_frac_ld;
      logic        tr_end;
      logic        eclip_b;
      logic        elem_init;
      logic        mem_b;
      op_ld_type   op_ld;
      logic        mul;
      res_dst_type res_dst;
      logic        elem_next;
      phase_type   phase;
   } ctl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic srch_stop;
      logic frac_trivial;
      logic trans;
      logic el_lt_end;
      logic nb_zero;
      logic elem_last;
   } dp_stat_type;

endpackage

@@ sv/kpb_div.sv @@
module kpb_div import kpb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [DIV_W-1:0] dividend,
   input  logic [31:0]      divisor,
   output logic             done,
   output logic [31:0]      rem,
   output logic [16:0]      quot
);

   logic [DIV_W-1:0]     dq_ff;
   logic [31:0]          rem_ff;
   logic [31:0]          div_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 run_ff;
   logic                 done_ff;
   logic [32:0]          trial;
   logic [33:0]          diff;
   logic                 take;

   assign trial = {rem_ff, dq_ff[DIV_W-1]};
   assign diff  = {1'b0, trial} - {2'b0, div_ff};
   assign take  = !diff[33];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == DIV_CNT_W'(DIV_W - 1));
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) run_ff <= 1'b0;
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // one quotient bit per cycle, restoring
   always_ff @(posedge clock) begin
      if (go) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (run_ff) begin
         dq_ff  <= {dq_ff[DIV_W-2:0], take};
         rem_ff <= take ? diff[31:0] : trial[31:0];
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;
   assign quot = dq_ff[16:0];

endmodule

@@ sv/kpb_ctrl.sv @@
module kpb_ctrl import kpb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  req_kind,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd,
   output logic        busy
);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   state_type after_p;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_A;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_A:    after_p = stat.trans ? ST_TR_ADD : ST_E_INIT;
         PH_TP:   after_p = ST_WRAPB;
         default: after_p = ST_E_INIT;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         ST_IDLE: if (start && req_kind == K_TICK) begin
            state_in = ST_WRAP;
            phase_in = PH_A;
         end
         ST_WRAP:   state_in = ST_WRAP_W;
         ST_WRAP_W: if (stat.div_done) state_in = ST_SRCH;
         ST_SRCH:   if (stat.srch_stop) state_in = ST_KT0;
         ST_KT0:    state_in = ST_KT1;
         ST_KT1:    state_in = ST_FRAC;
         ST_FRAC: if (stat.frac_trivial) begin
            state_in = after_p;
            if (phase_ff == PH_TP) phase_in = PH_B;
         end else begin
            state_in = ST_FRAC_W;
         end
         ST_FRAC_W: if (stat.div_done) begin
            state_in = after_p;
            if (phase_ff == PH_TP) phase_in = PH_B;
         end
         ST_TR_ADD: state_in = ST_TR_CHK;
         ST_TR_CHK: if (stat.el_lt_end) begin
            state_in = ST_FRAC;
            phase_in = PH_TP;
         end else begin
            state_in = ST_WRAPB;
            phase_in = PH_B;
         end
         ST_WRAPB:  state_in = ST_WRAP_W;
         ST_E_INIT: state_in = stat.nb_zero ? ST_IDLE : ST_E_RD;
         ST_E_RD:   state_in = ST_E_LD;
         ST_E_LD:   state_in = ST_E_MA;
         ST_E_MA:   state_in = stat.trans ? ST_E_MB : ST_E_AF;
         ST_E_MB:   state_in = ST_E_AB;
         ST_E_AB:   state_in = ST_E_MX;
         ST_E_MX:   state_in = ST_E_AF;
         ST_E_AF:   state_in = stat.elem_last ? ST_IDLE : ST_E_RD;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.phase = phase_ff;
      unique case (state_ff)
         ST_IDLE:   cmd.accept = start;
         ST_WRAP: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DV_WRAP_A;
         end
         ST_WRAP_W: cmd.wrap_ld = stat.div_done;
         ST_SRCH:   cmd.srch_step = !stat.srch_stop;
         ST_KT0:    cmd.kt0 = 1'b1;
         ST_KT1:    cmd.kt1 = 1'b1;
         ST_FRAC: if (stat.frac_trivial) begin
            cmd.p_ld = 1'b1;
         end else begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DV_FRAC;
         end
         ST_FRAC_W: cmd.p_ld = stat.div_done;
         ST_TR_ADD: cmd.tr_add = 1'b1;
         ST_TR_CHK: if (stat.el_lt_end) cmd.tr_frac_ld = 1'b1;
                    else cmd.tr_end = 1'b1;
         ST_WRAPB: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DV_WRAP_B;
            cmd.eclip_b = 1'b1;
         end
         ST_E_INIT: cmd.elem_init = 1'b1;
         ST_E_RD:   cmd.mem_b = 1'b0;
         ST_E_LD: begin
            cmd.op_ld = OP_MEM_A;
            cmd.mem_b = 1'b1;
         end
         ST_E_MA: begin
            cmd.mul = 1'b1;
            if (stat.trans) cmd.op_ld = OP_MEM_B;
         end
         ST_E_MB: begin
            cmd.mul     = 1'b1;
            cmd.res_dst = RD_BASE;
         end
         ST_E_AB:   cmd.op_ld = OP_MIX;
         ST_E_MX:   cmd.mul = 1'b1;
         ST_E_AF: begin
            cmd.res_dst   = RD_COL;
            cmd.elem_next = 1'b1;
         end
         default: cmd.accept = 1'b0;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ sv/kpb_dpath.sv @@
module kpb_dpath import kpb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ctl_cmd_type        cmd,
   input  logic [2:0]         req_kind,
   input  logic [31:0]        req_time_value,
   input  logic [31:0]        req_duration,
   input  logic [1:0]         req_clip_index,
   input  logic [2:0]         req_key_index,
   input  logic [3:0]         req_bone_index,
   input  logic [3:0]         req_element_index,
   input  logic signed [31:0] req_element_value,
   input  logic               req_final_key,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output dp_stat_type        stat,
   output logic               rsp_strobe,
   output logic [3:0]         rsp_out_bone,
   output logic [1:0]         rsp_out_row,
   output logic signed [31:0] rsp_col0,
   output logic signed [31:0] rsp_col1,
   output logic signed [31:0] rsp_col2,
   output logic signed [31:0] rsp_col3,
   output logic               rsp_last_row
);

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // configuration and playback state
   logic [NB_W-1:0]   bone_count_ff;
   logic [31:0]       len_ff [MAX_CLIPS];
   logic [31:0]       kt_ff [1 << KT_AW];
   logic [KCNT_W-1:0] kcnt_ff [MAX_CLIPS];
   logic [CLIP_W-1:0] cur_ff, nxt_ff;
   logic [31:0]       clip_time_ff, elapsed_ff, start_ff, end_ff;

   // tick working state
   logic [31:0]        dt_ff;
   logic [32:0]        sum_ff;
   logic [CLIP_W-1:0]  eclip_ff, ca_ff, cb_ff;
   logic               trans_ff;
   logic [31:0]        et_ff, tk_ff;
   logic [KCNT_W-1:0]  ek_ff;
   logic signed [32:0] num_ff, den_ff;
   logic [KEY_W-1:0]   ka_ff, da_ff, kb_ff, db_ff;
   logic [16:0]        pa_ff, pb_ff, tp_ff;
   logic [BONE_W-1:0]  bone_ff;
   logic [ELEM_W-1:0]  elem_ff;

   // element blend path
   logic signed [31:0] kmat_mem [1 << MAT_AW];
   logic signed [31:0] q0_ff, q1_ff;
   logic signed [31:0] op_a_ff, op_b_ff, hold_ff, base_ff;
   logic [16:0]        op_p_ff;
   logic signed [50:0] prod_ff, prod_in;
   logic signed [50:0] rnd;
   logic signed [31:0] res_in;
   logic signed [32:0] diff;
   logic signed [31:0] col_ff [4];
   logic               strobe_ff, last_ff;
   logic [3:0]         obone_ff;
   logic [1:0]         orow_ff;

   logic [NB_W-1:0]   nb;
   logic [31:0]       len_e;
   logic [KCNT_W-1:0] kc, n_e, kk, kt_idx, ek_inc;
   logic [31:0]       kt_val;
   logic [KEY_W-1:0]  d_sel;
   logic [16:0]       p_triv, p_val;
   logic [31:0]       wrap_res;
   logic [DIV_W-1:0]  div_dividend;
   logic [31:0]       div_divisor, div_rem;
   logic [16:0]       div_quot;
   logic              div_done;
   logic [MAT_AW-1:0] addr0, addr1;
   logic              acc_mat, acc_key, acc_play, acc_trans, acc_tick;

   assign acc_tick  = cmd.accept && (req_kind == K_TICK);
   assign acc_mat   = cmd.accept && (req_kind == K_LOAD_MAT);
   assign acc_key   = cmd.accept && (req_kind == K_LOAD_KEY);
   assign acc_play  = cmd.accept && (req_kind == K_PLAY);
   assign acc_trans = cmd.accept && (req_kind == K_TRANS);

   assign nb = (bone_count_ff > NB_W'(MAX_BONES)) ? NB_W'(MAX_BONES) : bone_count_ff;
   assign len_e = len_ff[eclip_ff];
   assign kc = kcnt_ff[eclip_ff];
   assign n_e = (kc == '0) ? KCNT_W'(1) : (kc > KCNT_W'(MAX_KEYS)) ? KCNT_W'(MAX_KEYS) : kc;
   assign kk = (ek_ff >= n_e) ? (n_e - 1'b1) : ek_ff;
   assign ek_inc = ek_ff + 1'b1;
   assign kt_idx = cmd.kt0 ? kk : (cmd.kt1 ? ek_inc : ek_ff);
   // a key at or past the count stands for the clip's end
   assign kt_val = (kt_idx >= n_e) ? len_e : kt_ff[{eclip_ff, kt_idx[KEY_W-1:0]}];
   assign d_sel = (ek_inc >= n_e) ? '0 : ek_inc[KEY_W-1:0];

   assign p_triv = (den_ff > 0 && num_ff > 0) ? P_ONE : 17'd0;
   assign p_val  = stat.frac_trivial ? p_triv : div_quot;
   assign wrap_res = (len_e == '0) ? 32'd0 : div_rem;

   always_comb begin
      case (cmd.div_sel)
         DV_WRAP_A: begin
            div_dividend = {15'd0, sum_ff};
            div_divisor  = len_ff[eclip_ff];
         end
         DV_WRAP_B: begin
            div_dividend = {16'd0, elapsed_ff};
            div_divisor  = len_ff[nxt_ff];
         end
         default: begin
            div_dividend = {num_ff[31:0], 16'd0};
            div_divisor  = den_ff[31:0];
         end
      endcase
   end

   kpb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .rem      (div_rem),
      .quot     (div_quot)
   );

   always_comb begin
      stat.div_done     = div_done;
      stat.srch_stop    = (ek_ff == '0) || !(et_ff < kt_val);
      stat.frac_trivial = (den_ff <= 0) || (num_ff <= 0) || (num_ff >= den_ff);
      stat.trans        = trans_ff;
      stat.el_lt_end    = (elapsed_ff < end_ff);
      stat.nb_zero      = (nb == '0);
      stat.elem_last    = ({1'b0, bone_ff} + 1'b1 == nb) && (elem_ff == '1);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bone_count_ff <= NB_W'(MAX_BONES);
         for (int i = 0; i < MAX_CLIPS; i++) len_ff[i] <= 32'd65536;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BONE_COUNT: bone_count_ff <= csr_data[NB_W-1:0];
            CSR_LEN0:       len_ff[0] <= csr_data;
            CSR_LEN1:       len_ff[1] <= csr_data;
            CSR_LEN2:       len_ff[2] <= csr_data;
            CSR_LEN3:       len_ff[3] <= csr_data;
            default:        bone_count_ff <= bone_count_ff;
         endcase
      end
   end

   // key store
   always_ff @(posedge clock) begin
      if (acc_key) kt_ff[{req_clip_index, req_key_index}] <= req_time_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CLIPS; i++) kcnt_ff[i] <= KCNT_W'(1);
      end else if (acc_key && req_final_key) begin
         kcnt_ff[req_clip_index] <= {1'b0, req_key_index} + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_mat) begin
         kmat_mem[{req_clip_index, req_key_index, req_bone_index, req_element_index}]
            <= req_element_value;
      end
   end

   assign addr0 = cmd.mem_b ? {cb_ff, kb_ff, bone_ff, elem_ff} : {ca_ff, ka_ff, bone_ff, elem_ff};
   assign addr1 = cmd.mem_b ? {cb_ff, db_ff, bone_ff, elem_ff} : {ca_ff, da_ff, bone_ff, elem_ff};

   always_ff @(posedge clock) begin
      q0_ff <= kmat_mem[addr0];
      q1_ff <= kmat_mem[addr1];
   end

   // playback state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         nxt_ff       <= '0;
         clip_time_ff <= '0;
         elapsed_ff   <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
      end else begin
         if (acc_play) begin
            cur_ff       <= req_clip_index;
            nxt_ff       <= req_clip_index;
            clip_time_ff <= req_time_value;
         end else if (acc_trans) begin
            // finish a crossfade still in flight
            if (cur_ff != nxt_ff) begin
               cur_ff       <= nxt_ff;
               clip_time_ff <= elapsed_ff;
            end
            nxt_ff     <= req_clip_index;
            start_ff   <= req_time_value;
            elapsed_ff <= req_time_value;
            end_ff     <= sat_add(req_time_value, req_duration);
         end else if (cmd.wrap_ld && cmd.phase == PH_A) begin
            clip_time_ff <= wrap_res;
         end else if (cmd.tr_add) begin
            elapsed_ff <= sat_add(elapsed_ff, dt_ff);
         end else if (cmd.tr_end) begin
            cur_ff       <= nxt_ff;
            clip_time_ff <= elapsed_ff;
         end
      end
   end

   // tick scalar path
   always_ff @(posedge clock) begin
      if (reset) begin
         trans_ff <= 1'b0;
         eclip_ff <= '0;
         ek_ff    <= '0;
      end else begin
         if (acc_tick) begin
            trans_ff <= (cur_ff != nxt_ff);
            eclip_ff <= cur_ff;
         end else if (cmd.eclip_b) begin
            eclip_ff <= nxt_ff;
         end
         if (cmd.wrap_ld) ek_ff <= n_e;
         else if (cmd.srch_step) ek_ff <= ek_ff - 1'b1;
         else if (cmd.kt0) ek_ff <= kk;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_tick) begin
         dt_ff  <= req_time_value;
         sum_ff <= {1'b0, clip_time_ff} + {1'b0, req_time_value};
      end
      if (cmd.wrap_ld) et_ff <= wrap_res;
      if (cmd.kt0) tk_ff <= kt_val;
      if (cmd.kt1) begin
         num_ff <= $signed({1'b0, et_ff}) - $signed({1'b0, tk_ff});
         den_ff <= $signed({1'b0, kt_val}) - $signed({1'b0, tk_ff});
         if (cmd.phase == PH_B) begin
            kb_ff <= ek_ff[KEY_W-1:0];
            db_ff <= d_sel;
            cb_ff <= eclip_ff;
         end else begin
            ka_ff <= ek_ff[KEY_W-1:0];
            da_ff <= d_sel;
            ca_ff <= eclip_ff;
         end
      end else if (cmd.tr_frac_ld) begin
         num_ff <= $signed({1'b0, elapsed_ff}) - $signed({1'b0, start_ff});
         den_ff <= $signed({1'b0, end_ff}) - $signed({1'b0, start_ff});
      end
      if (cmd.p_ld) begin
         case (cmd.phase)
            PH_A:    pa_ff <= p_val;
            PH_TP:   tp_ff <= p_val;
            default: pb_ff <= p_val;
         endcase
      end else if (cmd.tr_end) begin
         tp_ff <= P_ONE;
      end
   end

   // a + ((b - a) * p + half) >> 16
   assign diff    = $signed({op_b_ff[31], op_b_ff}) - $signed({op_a_ff[31], op_a_ff});
   assign prod_in = 51'(diff * $signed({1'b0, op_p_ff}));
   assign rnd     = prod_ff + 51'sd32768;
   assign res_in  = hold_ff + rnd[47:16];

   always_ff @(posedge clock) begin
      case (cmd.op_ld)
         OP_MEM_A: begin
            op_a_ff <= q0_ff;
            op_b_ff <= q1_ff;
            op_p_ff <= pa_ff;
         end
         OP_MEM_B: begin
            op_a_ff <= q0_ff;
            op_b_ff <= q1_ff;
            op_p_ff <= pb_ff;
         end
         OP_MIX: begin
            op_a_ff <= base_ff;
            op_b_ff <= res_in;
            op_p_ff <= tp_ff;
         end
         default: op_p_ff <= op_p_ff;
      endcase
      if (cmd.mul) begin
         prod_ff <= prod_in;
         hold_ff <= op_a_ff;
      end
      if (cmd.res_dst == RD_BASE) base_ff <= res_in;
      if (cmd.res_dst == RD_COL) col_ff[elem_ff[1:0]] <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bone_ff   <= '0;
         elem_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (cmd.res_dst == RD_COL) && (elem_ff[1:0] == 2'd3);
         if (cmd.elem_init) begin
            bone_ff <= '0;
            elem_ff <= '0;
         end else if (cmd.elem_next) begin
            elem_ff <= elem_ff + 1'b1;
            if (elem_ff == '1) bone_ff <= bone_ff + 1'b1;
         end
      end
   end

   // capture row tag with the last column
   always_ff @(posedge clock) begin
      if (cmd.res_dst == RD_COL && elem_ff[1:0] == 2'd3) begin
         obone_ff <= bone_ff;
         orow_ff  <= elem_ff[3:2];
         last_ff  <= stat.elem_last;
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_out_bone = obone_ff;
   assign rsp_out_row  = orow_ff;
   assign rsp_col0     = col_ff[0];
   assign rsp_col1     = col_ff[1];
   assign rsp_col2     = col_ff[2];
   assign rsp_col3     = col_ff[3];
   assign rsp_last_row = last_ff;

endmodule

@@ sv/keyframe_pose_blender.sv @@
// Load, play and transition words complete at the accept edge; busy stays low.
// During a crossfade a tick runs the key search for both clips and blends their poses;
// it then shows the rows one at a time, one strobe per bone row. A tick's length is set by the
// 48-step shared divider (time wrap, keyframe and fade fractions) and by the single
// multiplier that every element's blend goes through, one key read pair at a time.
// Synchronous reset clears playback state, presets key counts and registers; key data stays.
module keyframe_pose_blender import kpb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_kind,
   input  logic [31:0]        req_time_value,
   input  logic [31:0]        req_duration,
   input  logic [1:0]         req_clip_index,
   input  logic [2:0]         req_key_index,
   input  logic [3:0]         req_bone_index,
   input  logic [3:0]         req_element_index,
   input  logic signed [31:0] req_element_value,
   input  logic               req_final_key,
   output logic               rsp_strobe,
   output logic [3:0]         rsp_out_bone,
   output logic [1:0]         rsp_out_row,
   output logic signed [31:0] rsp_col0,
   output logic signed [31:0] rsp_col1,
   output logic signed [31:0] rsp_col2,
   output logic signed [31:0] rsp_col3,
   output logic               rsp_last_row,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   kpb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   kpb_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_kind          (req_kind),
      .req_time_value    (req_time_value),
      .req_duration      (req_duration),
      .req_clip_index    (req_clip_index),
      .req_key_index     (req_key_index),
      .req_bone_index    (req_bone_index),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .req_final_key     (req_final_key),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .stat              (stat),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_bone      (rsp_out_bone),
      .rsp_out_row       (rsp_out_row),
      .rsp_col0          (rsp_col0),
      .rsp_col1          (rsp_col1),
      .rsp_col2          (rsp_col2),
      .rsp_col3          (rsp_col3),
      .rsp_last_row      (rsp_last_row)
   );

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_row |-> !busy)
      else $error("last row shown while tick still running");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_row |-> busy)
      else $error("row shown with no tick in progress");

   a_row_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("rows on adjacent cycles");

   a_load_single: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_kind != K_TICK |=> !busy)
      else $error("non-tick word made the block busy");

endmodule
